[src/pidtw_pkg.sv]
// constants and helpers for the pid controller with twiddle auto-tuning
// used by pid_controller_twiddle_autotune_top; no dependencies
`default_nettype none

package pidtw_pkg;

   // frames in one tuning run; the averaging shift needs a power of two
   localparam int RUN_FRAMES  = 512;
   localparam int HALF_FRAMES = RUN_FRAMES / 2;
   localparam int HALF_SHIFT  = $clog2(HALF_FRAMES);
   localparam int FRAME_W     = $clog2(RUN_FRAMES + 1);

   localparam int ERR_W   = 16;   // Q6.10
   localparam int GAIN_W  = 32;   // Q8.24
   localparam int DELTA_W = 31;   // deltas are saturated to 2^31-1
   localparam int DTOT_W  = 34;
   localparam int SQ_W    = 48;
   localparam int DRIVE_W = 16;   // Q1.14

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_KP_INITIAL     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KI_INITIAL     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KD_INITIAL     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALREADY_TUNED  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_TOLERANCE = 3'd4;

   localparam logic [31:0] TOLERANCE_RESET = 32'd3355443;  // 0.2

   // starting deltas 0.01, 0.001, 0.1
   localparam logic [DELTA_W-1:0] DELTA_P_RESET = 31'd167772;
   localparam logic [DELTA_W-1:0] DELTA_I_RESET = 31'd16777;
   localparam logic [DELTA_W-1:0] DELTA_D_RESET = 31'd1677722;
   localparam logic [DELTA_W-1:0] DELTA_MAX     = 31'h7FFF_FFFF;

   // floor(x / 10) = (x * DIV10_MAGIC) >> 35 for any 32 bit x
   localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
   localparam int          DIV10_SHIFT = 35;

   localparam logic [1:0] STAGE_P = 2'd0;
   localparam logic [1:0] STAGE_I = 2'd1;
   localparam logic [1:0] STAGE_D = 2'd2;

   // saturate a 34 bit signed value to the signed 32 bit range
   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -34'sh0_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[src/pid_controller_twiddle_autotune_top.sv]
// pid controller with twiddle coordinate-descent gain tuning, stream in and out
// depends on pidtw_pkg
`default_nettype none

// One error sample in, one result out, one transaction per clock unless stalled.
// Three register stages: the input stage updates the controller state and the tuner,
// the next stage forms the three gain products, the last one sums, negates and clamps
// into the output register.
// The tuner's delta scaling (one 32x32 reciprocal multiply) and the squared error
// update sit in the input stage, so a new sample can follow every unstalled cycle.
// Configuration writes take effect at once and are meant only while idle.
module pid_controller_twiddle_autotune_top (
   input  wire                             clock,
   input  wire                             reset,
   // req_tdata: [15:0] error_sample
   input  wire                             req_tvalid,
   output logic                            req_tready,
   input  wire  [15:0]                     req_tdata,
   // rsp_tdata: [15:0] drive_value, [16] restart_request, [17] tuning_done,
   //            [19:18] tuning_stage_now, [23:20] zero
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   output logic [23:0]                     rsp_tdata,
   input  wire                             csr_we,
   input  wire  [pidtw_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [31:0]                     csr_wdata
);
   import pidtw_pkg::*;

   typedef enum logic [1:0] {
      PH_RAISE,
      PH_LOWER,
      PH_RESTORE
   } phase_type;

   // controller and tuner state
   logic signed [ERR_W-1:0]   last_error_ff, last_error_in;
   logic signed [31:0]        error_sum_ff, error_sum_in;
   logic signed [GAIN_W-1:0]  gain_ff [3];
   logic signed [GAIN_W-1:0]  gain_in [3];
   logic [DELTA_W-1:0]        delta_ff [3];
   logic [DELTA_W-1:0]        delta_in [3];
   logic [DTOT_W-1:0]         delta_total_ff, delta_total_in;
   logic [SQ_W-1:0]           sq_acc_ff, sq_acc_in;
   logic [SQ_W-1:0]           best_ff, best_in;
   logic [FRAME_W-1:0]        frame_ff, frame_in;
   logic [1:0]                stage_ff, stage_in;
   phase_type                 phase_ff, phase_in;
   logic                      tuned_ff, tuned_in;
   logic [31:0]               tol_ff, tol_in;

   // pipeline
   logic                      s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic                      s1_en, s2_en, out_en, req_accept;
   logic signed [ERR_W-1:0]   s1_err_ff;
   logic signed [31:0]        s1_sum_ff;
   logic signed [ERR_W:0]     s1_diff_ff;
   logic signed [GAIN_W-1:0]  s1_gain_ff [3];
   logic [3:0]                s1_flags_ff, s2_flags_ff;
   logic [3:0]                flags_in;
   logic signed [47:0]        s2_prod_p_ff;
   logic signed [63:0]        s2_prod_i_ff;
   logic signed [48:0]        s2_prod_d_ff;
   logic [23:0]               rsp_data_ff;

   // input stage datapath
   logic signed [ERR_W-1:0]   err;
   logic signed [ERR_W:0]     diff;
   logic signed [33:0]        sum_wide;
   logic signed [31:0]        sum_sat;
   logic signed [31:0]        sq;
   logic [SQ_W-1:0]           score;
   logic                      restart;
   logic                      better;
   logic signed [GAIN_W-1:0]  cur_gain;
   logic [DELTA_W-1:0]        cur_delta;
   logic [31:0]               div_x;
   logic [63:0]               div_prod;
   logic [28:0]               div_q;
   logic [31:0]               delta_up_wide;
   logic [DELTA_W-1:0]        delta_up, delta_dn;
   logic signed [GAIN_W-1:0]  gain_plus, gain_minus2;

   // output stage
   logic signed [65:0]        acc, neg;
   logic signed [DRIVE_W-1:0] drive;

   assign out_en     = !rsp_valid_ff || rsp_tready;
   assign s2_en      = !s2_valid_ff || out_en;
   assign s1_en      = !s1_valid_ff || s2_en;
   assign req_tready = s1_en;
   assign req_accept = req_tvalid && s1_en;

   assign err      = req_tdata[ERR_W-1:0];
   assign diff     = {err[ERR_W-1], err} - {last_error_ff[ERR_W-1], last_error_ff};
   assign sum_wide = {{2{error_sum_ff[31]}}, error_sum_ff} + 34'(err);
   assign sum_sat  = sat32(sum_wide);
   assign sq       = 32'(err) * 32'(err);
   assign score    = sq_acc_ff >> HALF_SHIFT;

   assign cur_gain  = gain_ff[stage_ff];
   assign cur_delta = delta_ff[stage_ff];
   assign better    = score < best_ff;

   // d*1.1 rounded is d + floor((d+5)/10), d*0.9 rounded is d - floor((d+4)/10)
   assign div_x         = {1'b0, cur_delta} + (better ? 32'd5 : 32'd4);
   assign div_prod      = 64'(div_x) * 64'(DIV10_MAGIC);
   assign div_q         = div_prod[63:DIV10_SHIFT];
   assign delta_up_wide = {1'b0, cur_delta} + {3'b000, div_q};
   assign delta_up      = delta_up_wide[31] ? DELTA_MAX : delta_up_wide[DELTA_W-1:0];
   assign delta_dn      = cur_delta - {2'b00, div_q};

   assign gain_plus   = sat32({{2{cur_gain[31]}}, cur_gain} + {3'b000, cur_delta});
   assign gain_minus2 = sat32({{2{cur_gain[31]}}, cur_gain} - {2'b00, cur_delta, 1'b0});

   always_comb begin
      last_error_in  = last_error_ff;
      error_sum_in   = error_sum_ff;
      gain_in        = gain_ff;
      delta_in       = delta_ff;
      delta_total_in = delta_total_ff;
      sq_acc_in      = sq_acc_ff;
      best_in        = best_ff;
      frame_in       = frame_ff;
      stage_in       = stage_ff;
      phase_in       = phase_ff;
      tuned_in       = tuned_ff;
      tol_in         = tol_ff;
      restart        = 1'b0;

      if (req_accept) begin
         last_error_in = err;
         error_sum_in  = sum_sat;
         if (!tuned_ff) begin
            if (frame_ff < FRAME_W'(HALF_FRAMES)) begin
               sq_acc_in = '0;
            end else if (frame_ff < FRAME_W'(RUN_FRAMES)) begin
               sq_acc_in = sq_acc_ff + {16'd0, sq[31:0]};
            end else begin
               // end of run: one twiddle step on the current gain
               sq_acc_in = score;
               restart   = 1'b1;
               if (best_ff == '0) begin
                  best_in = score;
               end else if (delta_total_ff < {2'b00, tol_ff}) begin
                  tuned_in = 1'b1;
               end else begin
                  case (phase_ff)
                     PH_RAISE: begin
                        gain_in[stage_ff] = gain_plus;
                        phase_in          = PH_LOWER;
                     end
                     PH_LOWER: begin
                        if (better) begin
                           best_in            = score;
                           delta_in[stage_ff] = delta_up;
                           phase_in           = PH_RAISE;
                        end else begin
                           gain_in[stage_ff] = gain_minus2;
                           phase_in          = PH_RESTORE;
                        end
                     end
                     PH_RESTORE: begin
                        if (better) begin
                           best_in            = score;
                           delta_in[stage_ff] = delta_up;
                        end else begin
                           gain_in[stage_ff]  = gain_plus;
                           delta_in[stage_ff] = delta_dn;
                        end
                        phase_in = PH_RAISE;
                     end
                     default: begin
                        phase_in = PH_RAISE;
                     end
                  endcase
                  // stage finished: move on, refresh the delta sum after the last gain
                  if (phase_in == PH_RAISE) begin
                     if (stage_ff == STAGE_D) begin
                        delta_total_in = {3'b000, delta_in[0]} + {3'b000, delta_in[1]}
                                       + {3'b000, delta_in[2]};
                        stage_in       = STAGE_P;
                     end else begin
                        stage_in = stage_ff + 2'd1;
                     end
                  end
               end
            end
            if (restart) begin
               frame_in      = '0;
               last_error_in = '0;
               error_sum_in  = '0;
            end else begin
               frame_in = frame_ff + FRAME_W'(1);
            end
         end
      end

      if (csr_we) begin
         case (csr_index)
            CSR_KP_INITIAL:     gain_in[0] = csr_wdata;
            CSR_KI_INITIAL:     gain_in[1] = csr_wdata;
            CSR_KD_INITIAL:     gain_in[2] = csr_wdata;
            CSR_ALREADY_TUNED:  tuned_in   = csr_wdata[0];
            CSR_GAIN_TOLERANCE: tol_in     = csr_wdata;
            default: ;
         endcase
      end
   end

   assign flags_in = {stage_in, tuned_in, restart};

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff  <= '0;
         error_sum_ff   <= '0;
         gain_ff        <= '{default: '0};
         delta_ff       <= '{DELTA_P_RESET, DELTA_I_RESET, DELTA_D_RESET};
         delta_total_ff <= '1;
         sq_acc_ff      <= '0;
         best_ff        <= '0;
         frame_ff       <= '0;
         stage_ff       <= STAGE_P;
         phase_ff       <= PH_RAISE;
         tuned_ff       <= 1'b0;
         tol_ff         <= TOLERANCE_RESET;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         last_error_ff  <= last_error_in;
         error_sum_ff   <= error_sum_in;
         gain_ff        <= gain_in;
         delta_ff       <= delta_in;
         delta_total_ff <= delta_total_in;
         sq_acc_ff      <= sq_acc_in;
         best_ff        <= best_in;
         frame_ff       <= frame_in;
         stage_ff       <= stage_in;
         phase_ff       <= phase_in;
         tuned_ff       <= tuned_in;
         tol_ff         <= tol_in;
         if (s1_en) begin
            s1_valid_ff <= req_accept;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_en) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   // drive uses the gains as they stood before this transaction's tuning step
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_err_ff   <= err;
         s1_sum_ff   <= sum_sat;
         s1_diff_ff  <= diff;
         s1_gain_ff  <= gain_ff;
         s1_flags_ff <= flags_in;
      end
      if (s2_en && s1_valid_ff) begin
         s2_prod_p_ff <= 48'(s1_gain_ff[0]) * 48'(s1_err_ff);
         s2_prod_i_ff <= 64'(s1_gain_ff[1]) * 64'(s1_sum_ff);
         s2_prod_d_ff <= 49'(s1_gain_ff[2]) * 49'(s1_diff_ff);
         s2_flags_ff  <= s1_flags_ff;
      end
      if (out_en && s2_valid_ff) begin
         rsp_data_ff <= {4'd0, s2_flags_ff, drive};
      end
   end

   // Q.34 sum, negated, clamped to +-1.0, floored to Q1.14
   assign acc = 66'(s2_prod_p_ff) + 66'(s2_prod_i_ff) + 66'(s2_prod_d_ff);
   assign neg = -acc;

   always_comb begin
      if (neg <= -66'sh4_0000_0000) begin
         drive = -16'sd16384;
      end else if (neg >= 66'sh4_0000_0000) begin
         drive = 16'sd16384;
      end else begin
         drive = neg[35:20];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_stage_range: assert property (@(posedge clock) disable iff (reset)
      stage_ff != 2'd3)
      else $error("tuning stage out of range");

   a_frame_bound: assert property (@(posedge clock) disable iff (reset)
      frame_ff <= FRAME_W'(RUN_FRAMES))
      else $error("frame count past the end of a run");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      req_accept && restart |=> frame_ff == '0 && error_sum_ff == '0)
      else $error("restart did not clear the run state");

   a_tuned_sticks: assert property (@(posedge clock) disable iff (reset)
      tuned_ff && !csr_we |=> tuned_ff)
      else $error("tuned flag dropped without a register write");

   a_delta_nonzero: assert property (@(posedge clock) disable iff (reset)
      delta_ff[0] != '0 && delta_ff[1] != '0 && delta_ff[2] != '0)
      else $error("tuning delta collapsed to zero");
`endif

endmodule

`default_nettype wire

[dv/pid_controller_twiddle_autotune_top_test.sv]
// self-checking stream testbench for pid_controller_twiddle_autotune_top
// predicts drive value and tuner flags per error sample; uses pidtw_pkg for constants
module pid_controller_twiddle_autotune_top_test;
   import pidtw_pkg::*;

   localparam int     RUN_LEN     = pidtw_pkg::RUN_FRAMES;
   localparam int     HALF_RUN    = RUN_LEN / 2;
   localparam longint ONE_Q34     = 64'sh4_0000_0000;
   localparam longint SUM_MAX     = 64'sh7FFF_FFFF;
   localparam longint SUM_MIN     = -64'sh8000_0000;
   localparam int     CYCLE_LIMIT = 2_000_000;

   typedef enum bit [1:0] {PH_RAISE, PH_LOWER, PH_RESTORE} tune_phase_type;

   typedef struct packed {
      logic [15:0] drive;
      logic        restart;
      logic        done;
      logic [1:0]  stage;
   } frame_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [15:0] error_sample
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [15:0] drive_value, [16] restart_request, [17] tuning_done,
   // [19:18] tuning_stage_now, [23:20] zero
   logic [23:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // controller and tuner state as it stands after reset
   longint      prev_err = 0;
   longint      err_total = 0;
   longint      gains[3] = '{0, 0, 0};
   longint      deltas[3] = '{167772, 16777, 1677722};
   bit [33:0]   delta_sum = '1;
   bit [47:0]   sq_acc = '0;
   bit [47:0]   best_sq = '0;
   int unsigned frame_no = 0;
   bit [1:0]    stage = STAGE_P;
   tune_phase_type phase = PH_RAISE;
   bit          tuned = 1'b0;
   bit [31:0]   tolerance_q24 = 32'd3355443;

   frame_out_type awaited_outputs[$];
   int          mismatch_count = 0;
   int          feed_gap_pct = 0;
   int          take_gap_pct = 0;
   int          stall_left = 0;
   int          cycles_run = 0;

   pid_controller_twiddle_autotune_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint clip32(input longint x);
      if (x > SUM_MAX) return SUM_MAX;
      if (x < SUM_MIN) return SUM_MIN;
      return x;
   endfunction

   function automatic longint scaled_delta(input longint d, input int mul);
      longint r;
      r = (d * mul + 5) / 10;
      return (r > SUM_MAX) ? SUM_MAX : r;
   endfunction

   function automatic void close_stage();
      phase = PH_RAISE;
      if (stage == STAGE_D) delta_sum = deltas[0] + deltas[1] + deltas[2];
      stage = (stage == STAGE_D) ? STAGE_P : stage + 2'd1;
   endfunction

   // one coordinate-descent step on the gain of the current stage
   function automatic void twiddle_step();
      int s;
      s = stage;
      if (best_sq == 0) begin
         best_sq = sq_acc;
         return;
      end
      if (delta_sum < tolerance_q24) begin
         tuned = 1'b1;
         return;
      end
      case (phase)
         PH_RAISE: begin
            gains[s] = clip32(gains[s] + deltas[s]);
            phase = PH_LOWER;
         end
         PH_LOWER: begin
            if (sq_acc < best_sq) begin
               best_sq = sq_acc;
               deltas[s] = scaled_delta(deltas[s], 11);
               close_stage();
            end else begin
               gains[s] = clip32(gains[s] - 2 * deltas[s]);
               phase = PH_RESTORE;
            end
         end
         default: begin
            if (sq_acc < best_sq) begin
               best_sq = sq_acc;
               deltas[s] = scaled_delta(deltas[s], 11);
            end else begin
               gains[s] = clip32(gains[s] + deltas[s]);
               deltas[s] = scaled_delta(deltas[s], 9);
            end
            close_stage();
         end
      endcase
   endfunction

   function automatic frame_out_type pid_frame_outputs(input logic signed [15:0] sample);
      longint     e;
      longint     diff;
      longint     neg;
      longint     drv;
      bit         restart;
      frame_out_type out;
      e = sample;
      restart = 1'b0;
      diff = e - prev_err;
      prev_err = e;
      err_total = clip32(err_total + e);
      neg = -(gains[0] * e + gains[1] * err_total + gains[2] * diff);
      if (neg <= -ONE_Q34) drv = -16384;
      else if (neg >= ONE_Q34) drv = 16384;
      else drv = neg >>> 20;
      if (!tuned) begin
         // first half of a run only warms up, second half is scored
         if (frame_no < HALF_RUN) begin
            sq_acc = '0;
         end else if (frame_no < RUN_LEN) begin
            sq_acc = sq_acc + e * e;
         end else begin
            if (frame_no == RUN_LEN) sq_acc = sq_acc / HALF_RUN;
            twiddle_step();
            restart = 1'b1;
         end
         if (restart) begin
            frame_no = 0;
            prev_err = 0;
            err_total = 0;
         end else if (frame_no < 'h1FFFF) begin
            frame_no++;
         end
      end
      out.drive   = drv[15:0];
      out.restart = restart;
      out.done    = tuned;
      out.stage   = stage;
      return out;
   endfunction

   task automatic note_mismatch(input string what);
      if (mismatch_count < 40) $display("mismatch: %s", what);
      mismatch_count++;
   endtask

   task automatic send_error(input logic signed [15:0] sample);
      while ($urandom_range(0, 99) < feed_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      awaited_outputs.push_back(pid_frame_outputs(sample));
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_outputs.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_KP_INITIAL:     gains[0] = $signed(value);
         CSR_KI_INITIAL:     gains[1] = $signed(value);
         CSR_KD_INITIAL:     gains[2] = $signed(value);
         CSR_ALREADY_TUNED:  tuned = value[0];
         CSR_GAIN_TOLERANCE: tolerance_q24 = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_idling(input int feed, input int take);
      feed_gap_pct = feed;
      take_gap_pct <= take;
   endtask

   function automatic logic [31:0] random_gain();
      return int'($urandom) >>> $urandom_range(0, 24);
   endfunction

   // runs of random amplitude, picked at each run start; some silent, some full-range noise
   task automatic send_tuning_runs(input int max_items, input bit stop_when_tuned);
      int amp;
      int sent;
      amp = 0;
      sent = 0;
      while (sent < max_items && !(stop_when_tuned && tuned)) begin
         if (frame_no == 0) begin
            case ($urandom_range(0, 7))
               0:       amp = 0;
               1:       amp = -1;
               default: amp = $urandom_range(1, 3000);
            endcase
         end
         if (amp < 0) send_error(16'($urandom));
         else send_error(16'(int'($urandom_range(0, 2 * amp)) - amp));
         sent++;
      end
   endtask

   task automatic test_directed_drive();
      int unit_steps[11] = '{0, 1, -1, 1023, 1024, -1024, -1025, 32767, -32768,
                             'h5555, 'hAAAA};
      drain_results();
      write_csr(CSR_ALREADY_TUNED, 32'd1);
      write_csr(CSR_KP_INITIAL, 32'h0100_0000);
      write_csr(CSR_KI_INITIAL, 32'd0);
      write_csr(CSR_KD_INITIAL, 32'd0);
      foreach (unit_steps[i]) send_error(16'(unit_steps[i]));
      // smallest gain shows rounding toward minus infinity
      drain_results();
      write_csr(CSR_KP_INITIAL, 32'd1);
      send_error(1);
      send_error(-1);
      send_error(3);
      send_error(-3);
      drain_results();
      write_csr(CSR_KP_INITIAL, 32'd0);
      write_csr(CSR_KD_INITIAL, 32'h0010_0000);
      send_error(100);
      send_error(0);
      send_error(-100);
      drain_results();
      write_csr(CSR_KP_INITIAL, 32'h8000_0000);
      write_csr(CSR_KI_INITIAL, 32'h7FFF_FFFF);
      write_csr(CSR_KD_INITIAL, 32'h8000_0000);
      send_error(-32768);
      send_error(32767);
      send_error(0);
      send_error(-1);
      send_error(2);
      send_error(0);
   endtask

   task automatic test_input_backpressure();
      drain_results();
      stall_left <= 400;
      repeat (60) send_error(16'($urandom));
   endtask

   task automatic test_silent_tuning_run();
      drain_results();
      write_csr(CSR_KP_INITIAL, 32'h7FFF_FFFF);
      write_csr(CSR_KI_INITIAL, 32'h0000_4000);
      write_csr(CSR_KD_INITIAL, 32'h8000_0000);
      write_csr(CSR_ALREADY_TUNED, 32'd0);
      // a silent run scores zero, so the tuner still waits for its first score
      repeat (RUN_LEN + 1) send_error(16'sd0);
   endtask

   task automatic test_random_tuning();
      drain_results();
      write_csr(CSR_KP_INITIAL, random_gain());
      write_csr(CSR_KI_INITIAL, random_gain());
      write_csr(CSR_KD_INITIAL, random_gain());
      write_csr(CSR_GAIN_TOLERANCE, 32'd0);
      send_tuning_runs(3 * (RUN_LEN + 1), 1'b0);
   endtask

   task automatic test_error_sum_extremes();
      drain_results();
      write_csr(CSR_KP_INITIAL, 32'd0);
      write_csr(CSR_KI_INITIAL, 32'h0001_0000);
      write_csr(CSR_KD_INITIAL, 32'd0);
      write_csr(CSR_ALREADY_TUNED, 32'd1);
      repeat (40) send_error(16'sh8000);
      repeat (40) send_error(16'sh7FFF);
      repeat (60) send_error(16'(int'($urandom_range(0, 4095)) - 2048));
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= take_gap_pct);
      end
   end

   always @(posedge clock) begin
      frame_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_outputs.size() == 0) begin
            note_mismatch($sformatf("result %h with no sample pending", rsp_tdata));
         end else begin
            want = awaited_outputs.pop_front();
            if (rsp_tdata[15:0] !== want.drive)
               note_mismatch($sformatf("drive_value %h, predicted %h",
                                       rsp_tdata[15:0], want.drive));
            if (rsp_tdata[16] !== want.restart)
               note_mismatch($sformatf("restart_request %b, predicted %b",
                                       rsp_tdata[16], want.restart));
            if (rsp_tdata[17] !== want.done)
               note_mismatch($sformatf("tuning_done %b, predicted %b",
                                       rsp_tdata[17], want.done));
            if (rsp_tdata[19:18] !== want.stage)
               note_mismatch($sformatf("tuning_stage_now %0d, predicted %0d",
                                       rsp_tdata[19:18], want.stage));
         end
      end
   end

   always @(posedge clock) begin
      cycles_run <= cycles_run + 1;
      if (cycles_run == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      set_idling(38, 47);
      test_directed_drive();
      test_input_backpressure();
      test_silent_tuning_run();
      set_idling(47, 38);
      test_random_tuning();
      set_idling(0, 0);
      test_error_sum_extremes();
      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[files.f]
src/pidtw_pkg.sv
src/pid_controller_twiddle_autotune_top.sv
dv/pid_controller_twiddle_autotune_top_test.sv
